>>> rtl/olist_pkg.sv
// Shared types and codes for the ordered list engine.
// No dependencies; every other file imports this package.
package olist_pkg;

  // Operation codes carried in the request beat
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_END   = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;

  // Status codes returned in the response beat
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Match bits examined per scan cycle
  localparam int SCAN_CHUNK = 8;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] item_value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found_position;
    logic [7:0] entry_count;
  } rsp_t;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic        ins;
    logic        del;
    logic [7:0]  slot;
    logic [31:0] value;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

>>> rtl/olist_cell.sv
// One storage cell of the list row: holds an entry and its valid bit.
// Depends on olist_pkg for the broadcast command type.
module olist_cell
  import olist_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_cmd_t   cmd,
  input  logic [7:0]  slot_id,
  input  logic [31:0] left_data,
  input  logic        left_valid,
  input  logic [31:0] right_data,
  input  logic        right_valid,
  output logic [31:0] data,
  output logic        valid,
  output logic        match
);

  logic after_slot;
  logic at_slot;

  assign after_slot = slot_id > cmd.slot;
  assign at_slot    = slot_id == cmd.slot;

  // Compare against the broadcast key
  assign match = valid && (data == cmd.value);

  // Shift toward the end on insert, toward the front on delete
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (after_slot) begin
        valid <= left_valid;
      end else if (at_slot) begin
        valid <= 1'b1;
      end
    end else if (cmd.del) begin
      if (after_slot || at_slot) begin
        valid <= right_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (after_slot) begin
        data <= left_data;
      end else if (at_slot) begin
        data <= cmd.value;
      end
    end else if (cmd.del) begin
      if (after_slot || at_slot) begin
        data <= right_data;
      end
    end
  end

endmodule

>>> rtl/ordered_list_engine.sv
// Top level of the ordered list engine: request decode, cell row, search scan.
// Depends on olist_pkg and olist_cell.
//
// Usage:
//   Request channel (req_valid/req_ready/req) carries op, item_value and
//   position. Response channel (rsp_valid/rsp_ready/rsp) returns one beat
//   per request: status, found_position and entry_count.
//   Inserts, deletes and unused op codes complete at the accepting edge;
//   the response beat is visible the next cycle, so one such request can
//   be taken every cycle while the receiver keeps up.
//   A search compares all cells in parallel at the accepting edge, then
//   walks the registered match vector 8 bits per cycle until a chunk
//   holds a hit or the last chunk is done. Requests are held off
//   during the scan.
//   The response sits in an output register; a new request is taken while
//   it is being drained in the same cycle. If the receiver stalls, the
//   beat holds and no new request is accepted.
//   Reset empties the list (count zero, all cells invalid) and drops any
//   pending response. No clearing pass is needed.
module ordered_list_engine
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CHUNKS = (CAPACITY + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int SCAN_W = CHUNKS * SCAN_CHUNK;
  localparam logic [7:0] LAST_BASE = 8'((CHUNKS - 1) * SCAN_CHUNK);

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [SCAN_W-1:0]          match;
  logic [7:0]                 scan_base;
  logic [2:0]                 first_idx;
  logic                       hit;
  logic                       accept;
  logic [8:0]                 count9;
  logic [8:0]                 pos9;
  logic                       full;
  logic                       empty;
  logic [2:0]                 status_now;
  logic                       do_ins;
  logic                       do_del;
  logic [7:0]                 slot;
  cell_cmd_t                  cmd;
  logic [CAPACITY-1:0][31:0]  cell_data;
  logic [CAPACITY-1:0]        cell_valid;
  logic [CAPACITY-1:0]        cell_match;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  assign count9 = 9'(count);
  assign pos9   = {1'b0, req.position};
  assign full   = count9 >= 9'(CAPACITY);
  assign empty  = count == '0;

  // Decode the request into a status and a cell command
  always_comb begin
    status_now = ST_OK;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    slot       = '0;
    case (req.op)
      OP_INS_FRONT: begin
        if (full) status_now = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_END: begin
        slot = 8'(count);
        if (full) status_now = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_AT: begin
        slot = req.position - 8'd1;
        if (req.position == 8'd0 || pos9 > count9 + 9'd1) status_now = ST_BADPOS;
        else if (full) status_now = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (empty) status_now = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_END: begin
        slot = 8'(count9 - 9'd1);
        if (empty) status_now = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_AT: begin
        slot = req.position - 8'd1;
        if (empty) status_now = ST_EMPTY;
        else if (req.position == 8'd0 || pos9 > count9) status_now = ST_BADPOS;
        else do_del = 1'b1;
      end
      OP_SEARCH: begin
        status_now = ST_OK;
      end
      default: begin
        status_now = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) count_next = count + CNT_W'(1);
    else if (do_del) count_next = count - CNT_W'(1);
  end

  assign cmd.ins   = accept && do_ins;
  assign cmd.del   = accept && do_del;
  assign cmd.slot  = slot;
  assign cmd.value = req.item_value;

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_d;
    logic        left_v;
    logic [31:0] right_d;
    logic        right_v;

    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_v = 1'b0;
    end else begin : g_link_l
      assign left_d = cell_data[i-1];
      assign left_v = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign right_v = 1'b0;
    end else begin : g_link_r
      assign right_d = cell_data[i+1];
      assign right_v = cell_valid[i+1];
    end

    olist_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .slot_id     (8'(i)),
      .left_data   (left_d),
      .left_valid  (left_v),
      .right_data  (right_d),
      .right_valid (right_v),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .match       (cell_match[i])
    );
  end

  // First set bit in the current scan chunk
  always_comb begin
    first_idx = '0;
    for (int k = SCAN_CHUNK - 1; k >= 0; k--) begin
      if (match[k]) first_idx = 3'(k);
    end
  end

  assign hit = |match[SCAN_CHUNK-1:0];

  // Control: state, count, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            if (req.op == OP_SEARCH) state <= S_SCAN;
            else rsp_valid <= 1'b1;
          end
        end
        S_SCAN: begin
          if (hit || scan_base == LAST_BASE) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: response beat, match vector, scan position
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp.status         <= status_now;
          rsp.found_position <= 8'd0;
          rsp.entry_count    <= 8'(count_next);
          match              <= SCAN_W'(cell_match);
          scan_base          <= 8'd0;
        end
      end
      S_SCAN: begin
        match              <= match >> SCAN_CHUNK;
        scan_base          <= scan_base + 8'(SCAN_CHUNK);
        rsp.status         <= hit ? ST_OK : ST_NOTFOUND;
        rsp.found_position <= hit ? scan_base + 8'(first_idx) + 8'd1 : 8'd0;
        rsp.entry_count    <= 8'(count);
      end
      default: begin
        scan_base <= scan_base;
      end
    endcase
  end

endmodule

>>> rtl/olist_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
// Depends on olist_pkg and ordered_list_engine.
module olist_checker
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // Hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // Non-search requests answer on the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req.op != OP_SEARCH |=> rsp_valid)
    else $error("insert/delete response not returned next cycle");

  // Count never exceeds capacity, and full means at capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= 8'(CAPACITY) && rsp.status <= ST_NOTFOUND)
    else $error("entry count or status out of range");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == 8'(CAPACITY))
    else $error("full status with list not at capacity");

  // A found position is reported only on success and within the list
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found_position != 8'd0
      |-> rsp.status == ST_OK && rsp.found_position <= rsp.entry_count)
    else $error("found position inconsistent with status or count");

endmodule

bind ordered_list_engine olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);
